### rtl/mtxws_pkg.sv
// Shared types and constants for the recursive mutex with waiter stack.
`default_nettype none

package mtxws_pkg;

  localparam int unsigned TASK_W         = 4;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned DEPTH_W        = 8;
  localparam int unsigned TASK_COUNT_DEF = 16;
  localparam int unsigned COUNT_MAX_DEF  = 255;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOCK    = 2'd0,
    REQ_TRYLOCK = 2'd1,
    REQ_UNLOCK  = 2'd2,
    REQ_CANCEL  = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_SATURATED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_LOCK    = 4'b0001,
    OP_TRYLOCK = 4'b0010,
    OP_UNLOCK  = 4'b0100,
    OP_CANCEL  = 4'b1000
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [TASK_W-1:0] task_id;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

`default_nettype wire

### rtl/mtxws_front.sv
// Request intake: decodes each beat into a command and queues it for the back end.
`default_nettype none

module mtxws_front import mtxws_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [TASK_W-1:0] task_id_i,
  output logic                   busy_o,
  output qhead_t                 head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cmd_t             cmd_d;
  logic             push, pop, full;

  always_comb begin
    cmd_d.task_id = task_id_i;
    unique case (req_e'(req_type_i))
      REQ_LOCK:    cmd_d.op = OP_LOCK;
      REQ_TRYLOCK: cmd_d.op = OP_TRYLOCK;
      REQ_UNLOCK:  cmd_d.op = OP_UNLOCK;
      REQ_CANCEL:  cmd_d.op = OP_CANCEL;
      default:     cmd_d.op = OP_CANCEL;
    endcase
  end

  assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push = start_i && !full;
  assign pop  = (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_d;
    end
  end

  assign busy_o       = full;
  assign head_o.valid = pop;
  assign head_o.cmd   = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/mtxws_back.sv
// Execution: owner, hold count and waiter cell chain, with the registered result beat.
`default_nettype none

module mtxws_back import mtxws_pkg::*; #(
  parameter int unsigned TASK_COUNT = TASK_COUNT_DEF,
  parameter int unsigned COUNT_MAX  = COUNT_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qhead_t              head_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     wake_valid_o,
  output logic [TASK_W-1:0]        wake_task_o,
  output logic                     owner_valid_o,
  output logic [TASK_W-1:0]        owner_task_o,
  output logic [DEPTH_W-1:0]       hold_depth_o
);

  localparam int unsigned IDX_W  = $clog2(TASK_COUNT);
  localparam int unsigned WCNT_W = $clog2(TASK_COUNT + 1);
  localparam int unsigned CNT_W  = $clog2(COUNT_MAX + 1);

  logic [TASK_W-1:0] stack_q [TASK_COUNT];
  logic [TASK_W-1:0] holder_q, holder_d;
  logic              held_q, held_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [WCNT_W-1:0] wcnt_q, wcnt_d;

  logic [TASK_COUNT-1:0] match, shift;
  logic [TASK_W-1:0]     req_task, top;
  logic                  found, is_owner;
  logic                  remove, push, pop;
  status_e               status_d;
  logic [TASK_W-1:0]     wake_task_d;

  logic                  done_q;
  logic [STATUS_W-1:0]   status_q;
  logic                  wake_valid_q;
  logic [TASK_W-1:0]     wake_task_q;
  logic                  owner_valid_q;
  logic [TASK_W-1:0]     owner_task_q;
  logic [DEPTH_W-1:0]    hold_depth_q;

  assign req_task = head_i.cmd.task_id;
  assign is_owner = held_q && (holder_q == req_task);
  assign top      = stack_q[IDX_W'(wcnt_q - 1'b1)];

  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      match[i] = (WCNT_W'(i) < wcnt_q) && (stack_q[i] == req_task);
    end
    shift[0] = match[0];
    for (int i = 1; i < TASK_COUNT; i++) begin
      shift[i] = shift[i-1] | match[i];
    end
  end

  assign found = |match;

  always_comb begin
    holder_d    = holder_q;
    held_d      = held_q;
    count_d     = count_q;
    remove      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    wake_task_d = '0;
    status_d    = ST_NOT_OWNER;
    unique case (head_i.cmd.op)
      OP_LOCK, OP_TRYLOCK: begin
        if (is_owner) begin
          if (count_q >= CNT_W'(COUNT_MAX)) begin
            status_d = ST_SATURATED;
          end else begin
            count_d  = count_q + 1'b1;
            status_d = ST_GRANTED;
          end
        end else if (!held_q) begin
          remove   = found;
          held_d   = 1'b1;
          holder_d = req_task;
          count_d  = CNT_W'(1);
          status_d = ST_GRANTED;
        end else if (head_i.cmd.op == OP_LOCK) begin
          if (found) begin
            status_d = ST_QUEUED;
          end else if (wcnt_q < WCNT_W'(TASK_COUNT)) begin
            push     = 1'b1;
            status_d = ST_QUEUED;
          end else begin
            status_d = ST_BUSY;
          end
        end else begin
          status_d = ST_BUSY;
        end
      end
      OP_UNLOCK: begin
        if (is_owner) begin
          status_d = ST_RELEASED;
          count_d  = count_q - 1'b1;
          if (count_q == CNT_W'(1)) begin
            held_d   = 1'b0;
            holder_d = '0;
            if (wcnt_q != '0) begin
              pop         = 1'b1;
              wake_task_d = top;
            end
          end
        end
      end
      OP_CANCEL: begin
        if (found) begin
          remove   = 1'b1;
          status_d = ST_BUSY;
        end
      end
      default: status_d = ST_NOT_OWNER;
    endcase
    wcnt_d = wcnt_q + WCNT_W'(push) - WCNT_W'(remove) - WCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holder_q <= '0;
      held_q   <= 1'b0;
      count_q  <= '0;
      wcnt_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= head_i.valid;
      if (head_i.valid) begin
        holder_q <= holder_d;
        held_q   <= held_d;
        count_q  <= count_d;
        wcnt_q   <= wcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_i.valid) begin
      status_q      <= status_d;
      wake_valid_q  <= pop;
      wake_task_q   <= wake_task_d;
      owner_valid_q <= held_d;
      owner_task_q  <= holder_d;
      hold_depth_q  <= DEPTH_W'(count_d);
    end
  end

  // waiter cells: removal closes the gap by pulling each entry down from above
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    if (i < TASK_COUNT - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (head_i.valid && remove && shift[i]) begin
          stack_q[i] <= stack_q[i+1];
        end else if (head_i.valid && push && (wcnt_q == WCNT_W'(i))) begin
          stack_q[i] <= req_task;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (head_i.valid && push && (wcnt_q == WCNT_W'(i))) begin
          stack_q[i] <= req_task;
        end
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign wake_valid_o  = wake_valid_q;
  assign wake_task_o   = wake_task_q;
  assign owner_valid_o = owner_valid_q;
  assign owner_task_o  = owner_task_q;
  assign hold_depth_o  = hold_depth_q;

endmodule

`default_nettype wire

### rtl/recursive_mutex_waiter_stack_core.sv
// Top level of the recursive mutex with a last-in-first-out waiter stack.
//
// One request beat is taken per cycle (start_i high, busy_o low) and yields exactly one
// result beat, shown on the result ports for a single cycle with done_o high, after it
// passes the command queue slot and then the result registers; results come out in
// request order and cannot be held off. The back end finishes a request every cycle:
// its waiter cell chain compares all waiters and closes a cancelled slot in one update,
// so the two-entry command queue drains at the intake rate and busy_o rises only when
// that queue is full. No clearing pass is needed after reset.
`default_nettype none

module recursive_mutex_waiter_stack_core import mtxws_pkg::*; #(
  parameter int unsigned TASK_COUNT = TASK_COUNT_DEF,
  parameter int unsigned COUNT_MAX  = COUNT_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [REQ_W-1:0]    req_type_i,
  input  wire logic [TASK_W-1:0]   task_id_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     wake_valid_o,
  output logic [TASK_W-1:0]        wake_task_o,
  output logic                     owner_valid_o,
  output logic [TASK_W-1:0]        owner_task_o,
  output logic [DEPTH_W-1:0]       hold_depth_o
);

  qhead_t head;

  mtxws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .task_id_i  (task_id_i),
    .busy_o     (busy_o),
    .head_o     (head)
  );

  mtxws_back #(
    .TASK_COUNT (TASK_COUNT),
    .COUNT_MAX  (COUNT_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .done_o        (done_o),
    .status_o      (status_o),
    .wake_valid_o  (wake_valid_o),
    .wake_task_o   (wake_task_o),
    .owner_valid_o (owner_valid_o),
    .owner_task_o  (owner_task_o),
    .hold_depth_o  (hold_depth_o)
  );

endmodule

`default_nettype wire

### rtl/mtxws_checker.sv
// Port-level assertions for the mutex core, bound to the top level.
`default_nettype none

module mtxws_checker import mtxws_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                done_o,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic                wake_valid_o,
  input wire logic [TASK_W-1:0]   owner_task_o,
  input wire logic                owner_valid_o,
  input wire logic [DEPTH_W-1:0]  hold_depth_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted beat gave no result two cycles later");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result beat without a matching request");

  a_wake_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && wake_valid_o) |-> (status_o == ST_RELEASED) && !owner_valid_o)
    else $error("wake-up outside a final release");

  a_free_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !owner_valid_o) |-> (owner_task_o == '0) && (hold_depth_o == '0))
    else $error("free mutex reports an owner or hold count");

endmodule

bind recursive_mutex_waiter_stack_core mtxws_checker u_mtxws_checker (.*);

`default_nettype wire
